>>> rtl/core/psa_pkg.sv
// Package for the packet slot allocator: pool size, field widths, codes,
// item and result structs, controller states and control struct.
// No dependencies.
package psa_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int SIZE_W  = 24;
  localparam int REL_W   = 8;
  localparam int GRANT_W = 4;
  localparam int COUNT_W = 5;

  localparam logic [SIZE_W-1:0] DEFAULT_SIZE_RST = SIZE_W'(4096);

  typedef enum logic [1:0] {
    CMD_ACQUIRE  = 2'd0,
    CMD_RELEASE  = 2'd1,
    CMD_INIT     = 2'd2,
    CMD_SHUTDOWN = 2'd3
  } psa_cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_INIT = 2'd1,
    ST_NO_FREE  = 2'd2,
    ST_BAD_SLOT = 2'd3
  } psa_status_t;

  typedef struct packed {
    psa_cmd_t           cmd;
    logic [SIZE_W-1:0]  request_size;
    logic [REL_W-1:0]   release_slot;
  } psa_req_t;

  typedef struct packed {
    psa_status_t         status;
    logic [GRANT_W-1:0]  granted_slot;
    logic                new_buffer;
    logic [SIZE_W-1:0]   buffer_size;
    logic [COUNT_W-1:0]  active_count;
    logic [COUNT_W-1:0]  peak_count;
  } psa_res_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } psa_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } psa_ctl_t;

endpackage

>>> rtl/core/packet_slot_allocator.sv
// Top level of the packet slot allocator: controller plus datapath.
// Depends on psa_pkg, psa_ctrl, psa_dpath.
//
//   channel   ports                          accepted when
//   item      start, busy, request           start && !busy
//   result    done, result                   done (one cycle, no stall)
//   config    cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
// An item executes the cycle after it is taken, and its result is shown with
// done in the cycle after that, while the next item may already be taken. No
// new item is taken while the single execute state of the sequencer holds busy.
// Reset is synchronous; after it the pool is not ready and the default size is
// 4096. The receiver cannot stall results.
module packet_slot_allocator import psa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  psa_req_t          request,
  output logic              done,
  output psa_res_t          result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  psa_ctl_t ctl;

  assign cfg_ready = ~busy;

  psa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  psa_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .request  (request),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .result   (result)
  );

endmodule

>>> rtl/core/psa_ctrl.sv
// Controller for the packet slot allocator: two-state sequencer plus done strobe.
// Depends on psa_pkg.
module psa_ctrl import psa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output psa_ctl_t ctl
);

  psa_state_t state, state_next;
  logic       done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (start) state_next = FSM_EXEC;
      end
      FSM_EXEC: begin
        state_next = FSM_IDLE;
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state == FSM_EXEC);
    ctl.load  = start && (state == FSM_IDLE);
    ctl.exec  = (state == FSM_EXEC);
    done_next = (state == FSM_EXEC);
  end

  a_exec_then_done: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |=> done) else $error("result strobe missing after execute");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(done)) else $error("result strobe held two cycles");

endmodule

>>> rtl/core/psa_dpath.sv
// Datapath for the packet slot allocator: slot bitmap, capacity store,
// counters, default size register, first-free search and result register.
// Depends on psa_pkg.
module psa_dpath import psa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  psa_ctl_t          ctl,
  input  psa_req_t          request,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data,
  output psa_res_t          result
);

  psa_req_t           req_q;
  psa_res_t           res, res_next;
  logic [SIZE_W-1:0]  default_size;
  logic [SLOTS-1:0]   busy_bits, busy_bits_next;
  logic [SLOTS-1:0]   cap_valid, cap_valid_next;
  logic [SIZE_W-1:0]  cap_mem [SLOTS];
  logic [SIZE_W-1:0]  cap_q;
  logic [CNT_W-1:0]   active, active_next;
  logic [CNT_W-1:0]   peak, peak_next;
  logic               pool_ready, pool_ready_next;

  logic               free_found;
  logic [SLOT_W-1:0]  free_idx;
  logic [SIZE_W-1:0]  need, cap_rd, new_cap;
  logic               realloc, cap_we;
  logic [SLOT_W-1:0]  rel_idx;
  logic               rel_ok;

  // first free slot, lowest index wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_bits[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // bitmap only changes on execute, so the slot read at load is the one granted
  assign need    = (req_q.request_size != '0) ? req_q.request_size : default_size;
  assign cap_rd  = cap_valid[free_idx] ? cap_q : '0;
  assign realloc = (cap_rd == '0) || (cap_rd < need);
  assign new_cap = realloc ? need : cap_rd;
  assign rel_idx = req_q.release_slot[SLOT_W-1:0];
  assign rel_ok  = ({1'b0, req_q.release_slot} < (REL_W + 1)'(SLOTS)) && busy_bits[rel_idx];

  always_comb begin
    busy_bits_next  = busy_bits;
    cap_valid_next  = cap_valid;
    active_next     = active;
    peak_next       = peak;
    pool_ready_next = pool_ready;
    cap_we          = 1'b0;
    res_next        = '0;
    res_next.status = ST_OK;
    priority if (req_q.cmd == CMD_INIT || req_q.cmd == CMD_SHUTDOWN) begin
      busy_bits_next  = '0;
      cap_valid_next  = '0;
      active_next     = '0;
      peak_next       = '0;
      pool_ready_next = (req_q.cmd == CMD_INIT);
    end else if (!pool_ready) begin
      res_next.status = ST_NOT_INIT;
    end else if (req_q.cmd == CMD_ACQUIRE) begin
      if (free_found) begin
        cap_we                   = 1'b1;
        busy_bits_next[free_idx] = 1'b1;
        cap_valid_next[free_idx] = 1'b1;
        active_next              = CNT_W'(active + 1'b1);
        if (active_next > peak) peak_next = active_next;
        res_next.granted_slot    = GRANT_W'(free_idx);
        res_next.new_buffer      = realloc;
        res_next.buffer_size     = new_cap;
      end else begin
        res_next.status = ST_NO_FREE;
      end
    end else begin
      if (rel_ok) begin
        busy_bits_next[rel_idx] = 1'b0;
        if (active != '0) active_next = CNT_W'(active - 1'b1);
      end else begin
        res_next.status = ST_BAD_SLOT;
      end
    end
    res_next.active_count = COUNT_W'(active_next);
    res_next.peak_count   = COUNT_W'(peak_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_bits    <= '0;
      cap_valid    <= '0;
      active       <= '0;
      peak         <= '0;
      pool_ready   <= 1'b0;
      default_size <= DEFAULT_SIZE_RST;
    end else begin
      if (cfg_we) default_size <= cfg_data;
      if (ctl.exec) begin
        busy_bits  <= busy_bits_next;
        cap_valid  <= cap_valid_next;
        active     <= active_next;
        peak       <= peak_next;
        pool_ready <= pool_ready_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) req_q <= request;
    if (ctl.load) cap_q <= cap_mem[free_idx];
    if (ctl.exec) res <= res_next;
    if (ctl.exec && cap_we) cap_mem[free_idx] <= new_cap;
  end

  assign result = res;

  a_active_le_peak: assert property (@(posedge clk) disable iff (rst)
    active <= peak) else $error("active count above peak");
  a_active_matches_bitmap: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(busy_bits)) == active) else $error("active count off bitmap");
  a_idle_pool_empty: assert property (@(posedge clk) disable iff (rst)
    !pool_ready |-> (busy_bits == '0)) else $error("busy slot in pool not ready");
  a_busy_has_cap: assert property (@(posedge clk) disable iff (rst)
    (busy_bits & ~cap_valid) == '0) else $error("busy slot without capacity");

endmodule
